// ----- hdl/twct_pkg.sv -----
// Shared types and constants of the time-window cue trigger.
package twct_pkg;

   // Field widths of the request and response beats
   localparam int IDX_W      = 5;
   localparam int TIME_W     = 24;
   localparam int ACT_W      = 4;
   localparam int PARAM_W    = 8;
   localparam int OP_W       = 3;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 16;

   // Configuration port
   localparam int ACTIVE_W   = 6;
   localparam int MASK_W     = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACTIVE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MASK   = 1'b1;

   // Parameter value of an action that was never set
   localparam logic signed [PARAM_W-1:0] PARAM_NONE = -8'sd1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 3'd0,
      OP_TICK  = 3'd1,
      OP_CLEAR = 3'd2,
      OP_POLL  = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   // Request tdata, lowest field last
   typedef struct packed {
      logic [6:0]                pad;
      logic [TIME_W-1:0]         position;
      logic signed [PARAM_W-1:0] action_param;
      logic [ACT_W-1:0]          action_id;
      logic [TIME_W-1:0]         window_end;
      logic [TIME_W-1:0]         window_start;
      logic [IDX_W-1:0]          entry_index;
   } req_payload_type;

   // Response tdata, lowest field last
   typedef struct packed {
      logic [6:0]                pad;
      logic signed [PARAM_W-1:0] param_out;
      logic                      fired;
   } rsp_payload_type;

   // One word of the cue table
   typedef struct packed {
      logic [TIME_W-1:0]  t_start;
      logic [TIME_W-1:0]  t_stop;
      logic [ACT_W-1:0]   action;
      logic [PARAM_W-1:0] param;
   } cue_entry_type;

   // Action update issued by the walk for one entry
   typedef struct packed {
      logic               set;
      logic               clr;
      logic [ACT_W-1:0]   action;
      logic [PARAM_W-1:0] param;
   } act_upd_type;

endpackage

// ----- hdl/twct_cue_mem.sv -----
// Cue table memory: one write port, one registered read port.
module twct_cue_mem #(
   parameter int ENTRIES = 32,
   parameter int EW      = 5
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [EW-1:0]          wr_addr,
   input  twct_pkg::cue_entry_type wr_data,
   input  logic                   rd_en,
   input  logic [EW-1:0]          rd_addr,
   output twct_pkg::cue_entry_type rd_data
);
   import twct_pkg::*;

   cue_entry_type mem [ENTRIES];
   cue_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/twct_act_store.sv -----
// Per-action state: parameter memory with valid bits, and pending flags.
module twct_act_store #(
   parameter int ACTIONS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  twct_pkg::act_upd_type         upd,
   input  logic                          clear_all,
   input  logic                          rd_en,
   input  logic [twct_pkg::ACT_W-1:0]    rd_act,
   input  logic                          poll_clr,
   output logic                          pend_bit,
   output logic signed [twct_pkg::PARAM_W-1:0] rd_param
);
   import twct_pkg::*;

   localparam int AW = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;

   logic [PARAM_W-1:0] val_mem [ACTIONS];
   logic [ACTIONS-1:0] pend_ff;
   logic [ACTIONS-1:0] vld_ff;
   logic [PARAM_W-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic               rd_rng_ff;

   logic          upd_rng;
   logic          rd_rng;
   logic [AW-1:0] upd_idx;
   logic [AW-1:0] rd_idx;

   assign upd_rng = 32'(upd.action) < ACTIONS;
   assign rd_rng  = 32'(rd_act) < ACTIONS;
   assign upd_idx = AW'(upd.action);
   assign rd_idx  = AW'(rd_act);

   // pending flag of the addressed action, zero out of range
   assign pend_bit = rd_rng ? pend_ff[rd_idx] : 1'b0;

   // flags: set/clear from the walk, poll clear, bulk clear
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         vld_ff  <= '0;
      end else begin
         if (clear_all) begin
            pend_ff <= '0;
         end else if (upd.set && upd_rng) begin
            pend_ff[upd_idx] <= 1'b1;
         end else if (upd.clr && upd_rng) begin
            pend_ff[upd_idx] <= 1'b0;
         end else if (poll_clr && rd_rng) begin
            pend_ff[rd_idx] <= 1'b0;
         end
         if (upd.set && upd_rng) begin
            vld_ff[upd_idx] <= 1'b1;
         end
      end
   end

   // parameter memory write
   always_ff @(posedge clock) begin
      if (upd.set && upd_rng) begin
         val_mem[upd_idx] <= upd.param;
      end
   end

   // parameter memory read, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= val_mem[rd_idx];
         rd_vld_ff  <= rd_rng ? vld_ff[rd_idx] : 1'b0;
         rd_rng_ff  <= rd_rng;
      end
   end

   // never-set actions read as minus one, out-of-range actions as zero
   assign rd_param = !rd_rng_ff ? '0 : (rd_vld_ff ? $signed(rd_data_ff) : PARAM_NONE);

endmodule

// ----- hdl/twct_walk.sv -----
// Tick walk: streams cue entries out of the table and evaluates each one.
module twct_walk #(
   parameter int ENTRIES = 32,
   parameter int ACTIONS = 16,
   parameter int EW      = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [twct_pkg::TIME_W-1:0]    position,
   input  logic [twct_pkg::ACTIVE_W-1:0]  active_entries,
   input  logic [twct_pkg::MASK_W-1:0]    one_shot_mask,
   input  logic                           clear_used,
   output logic                           rd_en,
   output logic [EW-1:0]                  rd_addr,
   input  twct_pkg::cue_entry_type        rd_data,
   output twct_pkg::act_upd_type          upd,
   output logic                           busy
);
   import twct_pkg::*;

   localparam int CW = $clog2(ENTRIES + 1);

   logic [CW-1:0]      rd_cnt_ff;
   logic [CW-1:0]      lim_ff;
   logic [CW-1:0]      lim_in;
   logic [TIME_W-1:0]  pos_ff;
   logic               ev_vld_ff;
   logic [EW-1:0]      ev_idx_ff;
   logic [ENTRIES-1:0] used_ff;

   logic issue;
   logic rng;
   logic hit;
   logic used_cur;
   logic one_shot;
   logic fire;
   logic drop;

   // walk length saturates at the table depth
   assign lim_in = (32'(active_entries) > ENTRIES) ? CW'(ENTRIES) : CW'(active_entries);

   assign issue   = rd_cnt_ff != lim_ff;
   assign rd_en   = issue;
   assign rd_addr = rd_cnt_ff[EW-1:0];
   assign busy    = issue || ev_vld_ff;

   // read sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff <= '0;
         lim_ff    <= '0;
         ev_vld_ff <= 1'b0;
      end else if (start) begin
         rd_cnt_ff <= '0;
         lim_ff    <= lim_in;
         ev_vld_ff <= 1'b0;
      end else begin
         ev_vld_ff <= issue;
         if (issue) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pos_ff <= position;
      end
      ev_idx_ff <= rd_addr;
   end

   // entry evaluation on the registered table word
   assign rng      = 32'(rd_data.action) < ACTIONS;
   assign hit      = (rd_data.t_start < pos_ff) && (pos_ff < rd_data.t_stop);
   assign used_cur = used_ff[ev_idx_ff];
   assign one_shot = one_shot_mask[rd_data.action];
   assign fire     = ev_vld_ff && rng && hit && !(one_shot && used_cur);
   assign drop     = ev_vld_ff && rng && !hit && used_cur && (pos_ff >= rd_data.t_stop);

   // used marks
   always_ff @(posedge clock) begin
      if (reset || clear_used) begin
         used_ff <= '0;
      end else if (fire) begin
         used_ff[ev_idx_ff] <= 1'b1;
      end else if (drop) begin
         used_ff[ev_idx_ff] <= 1'b0;
      end
   end

   assign upd.set    = fire;
   assign upd.clr    = drop;
   assign upd.action = rd_data.action;
   assign upd.param  = rd_data.param;

endmodule

// ----- hdl/time_window_cue_trigger_core.sv -----
// Top level of the time-window cue trigger.
//
// Requests arrive on req_ (tuser = opcode, tdata = entry fields and tick
// position); every request gives exactly one response beat on rsp_
// (fired flag and action parameter). Registers are to be written on csr_
// only while the block is idle; the block itself does not enforce it.
// A load, clear or unknown opcode goes from accept straight to ST_DONE,
// a poll or read passes ST_READ on the way, and a tick stays in ST_WALK
// until the walk is done; ST_DONE loads the response once the output
// register is free and the block is then ready for the next request.
// A tick reads the cue table memory one entry per cycle through its
// single read port, which sets its length.
// Reset clears the used marks, pending flags and parameter valid bits
// (parameters then read as minus one); the cue table itself holds no
// reset value and needs no clearing pass.
// A finished response waits in the output register while rsp_tready is
// low; one more request is accepted and its result is held until the
// output register frees up.
module time_window_cue_trigger_core #(
   parameter int ENTRIES = 32,
   parameter int ACTIONS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index, window_start, window_end, action_id, action_param, position
   input  logic [twct_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode
   input  logic [twct_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // fired, param_out
   output logic [twct_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wen,
   input  logic [twct_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [twct_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import twct_pkg::*;

   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_WALK = 4'b0010,
      ST_READ = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [ACTIVE_W-1:0]       active_ff;
   logic [MASK_W-1:0]         mask_ff;
   logic                      res_fired_ff;
   logic signed [PARAM_W-1:0] res_param_ff;
   rsp_payload_type           rsp_data_ff;
   logic                      rsp_vld_ff;

   req_payload_type req;
   op_type          op;
   logic            accept;
   logic            out_free;

   logic          cue_wr_en;
   cue_entry_type cue_wr_data;
   logic          cue_rd_en;
   logic [EW-1:0] cue_rd_addr;
   cue_entry_type cue_rd_data;

   act_upd_type               upd;
   logic                      walk_busy;
   logic                      pend_bit;
   logic signed [PARAM_W-1:0] rd_param;

   assign req      = req_payload_type'(req_tdata);
   assign op       = op_type'(req_tuser);
   assign req_tready = state_ff == ST_IDLE;
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_vld_ff || rsp_tready;

   // table load
   assign cue_wr_en           = accept && (op == OP_LOAD) && (32'(req.entry_index) < ENTRIES);
   assign cue_wr_data.t_start = req.window_start;
   assign cue_wr_data.t_stop  = req.window_end;
   assign cue_wr_data.action  = req.action_id;
   assign cue_wr_data.param   = req.action_param;

   twct_cue_mem #(.ENTRIES(ENTRIES), .EW(EW)) u_cue_mem (
      .clock   (clock),
      .wr_en   (cue_wr_en),
      .wr_addr (EW'(req.entry_index)),
      .wr_data (cue_wr_data),
      .rd_en   (cue_rd_en),
      .rd_addr (cue_rd_addr),
      .rd_data (cue_rd_data)
   );

   twct_walk #(.ENTRIES(ENTRIES), .ACTIONS(ACTIONS), .EW(EW)) u_walk (
      .clock          (clock),
      .reset          (reset),
      .start          (accept && (op == OP_TICK)),
      .position       (req.position),
      .active_entries (active_ff),
      .one_shot_mask  (mask_ff),
      .clear_used     (accept && (op == OP_CLEAR)),
      .rd_en          (cue_rd_en),
      .rd_addr        (cue_rd_addr),
      .rd_data        (cue_rd_data),
      .upd            (upd),
      .busy           (walk_busy)
   );

   twct_act_store #(.ACTIONS(ACTIONS)) u_act_store (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .clear_all (accept && (op == OP_CLEAR)),
      .rd_en     (accept && ((op == OP_POLL) || (op == OP_READ))),
      .rd_act    (req.action_id),
      .poll_clr  (accept && (op == OP_POLL) && mask_ff[req.action_id]),
      .pend_bit  (pend_bit),
      .rd_param  (rd_param)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_TICK: state_in = ST_WALK;
                  OP_POLL: state_in = ST_READ;
                  OP_READ: state_in = ST_READ;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: if (!walk_busy) state_in = ST_DONE;
         ST_READ: state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // result assembly
   always_ff @(posedge clock) begin
      if (accept) begin
         res_fired_ff <= (op == OP_POLL) ? pend_bit : 1'b0;
         res_param_ff <= '0;
      end else if (state_ff == ST_READ) begin
         res_param_ff <= rd_param;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_data_ff.pad       <= '0;
         rsp_data_ff.param_out <= res_param_ff;
         rsp_data_ff.fired     <= res_fired_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         mask_ff   <= '1;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_ACTIVE: active_ff <= csr_wdata[ACTIVE_W-1:0];
            CSR_MASK:   mask_ff   <= csr_wdata[MASK_W-1:0];
            default:    ;
         endcase
      end
   end

endmodule

// ----- hdl/twct_checker.sv -----
// Port-level checks of the cue trigger core, bound to the top level.
module twct_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [twct_pkg::OP_W-1:0]       req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [twct_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import twct_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed under stall");

   // one request in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in flight");

   // load and clear, taken with the output empty, answer with an all-zero beat
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid &&
      ((req_tuser == OP_LOAD) || (req_tuser == OP_CLEAR))
      |=> ##1 rsp_tvalid && (rsp_tdata == '0))
      else $error("load or clear gave a wrong response");

   // reset leaves the block empty and ready
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind time_window_cue_trigger_core twct_checker u_twct_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking bench for the time-window cue trigger: directed and random request streams.
module tb_top;
   import twct_pkg::*;

   localparam int ENTRIES    = 32;
   localparam int ACTIONS    = 16;
   localparam int PHASES     = 7;
   localparam int PHASE_REQS = 160;
   // timeline span of the random playback, 16.8 fixed point
   localparam int TL_SPAN    = 2600;
   localparam int WIN_SPAN   = 2047;
   localparam int MAX_LEN    = 400;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      req_payload_type fields;
   } cue_request_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [OP_W-1:0]         req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   time_window_cue_trigger_core #(
      .ENTRIES (ENTRIES),
      .ACTIONS (ACTIONS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the cue table, flags and registers
   logic [TIME_W-1:0]  tbl_start  [ENTRIES];
   logic [TIME_W-1:0]  tbl_end    [ENTRIES];
   logic [ACT_W-1:0]   tbl_action [ENTRIES];
   logic [PARAM_W-1:0] tbl_param  [ENTRIES];
   bit                 tbl_used   [ENTRIES];
   bit                 act_pending[ACTIONS];
   logic [PARAM_W-1:0] act_value  [ACTIONS];
   logic [ACTIVE_W-1:0] cfg_active  = '0;
   logic [MASK_W-1:0]   cfg_oneshot = '1;

   cue_request_type request_q[$];
   rsp_payload_type predicted_q[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int tl_pos         = 0;
   int mismatch_count = 0;
   int req_count      = 0;
   int tick_count     = 0;
   int poll_hits      = 0;
   int rsp_count      = 0;
   int setting_count  = 0;

   initial begin
      for (int i = 0; i < ENTRIES; i++) tbl_used[i] = 1'b0;
      for (int a = 0; a < ACTIONS; a++) begin
         act_pending[a] = 1'b0;
         act_value[a]   = PARAM_NONE;
      end
   end

   // Append one beat to the pending requests
   function automatic void add_request(input cue_request_type r);
      request_q.insert(request_q.size(), r);
   endfunction

   // Walk the active entries for one timeline position
   function automatic void walk_cues(input logic [TIME_W-1:0] pos);
      int n;
      logic [ACT_W-1:0] a;
      n = (cfg_active > ENTRIES) ? ENTRIES : int'(cfg_active);
      for (int i = 0; i < n; i++) begin
         a = tbl_action[i];
         if (tbl_start[i] < pos && pos < tbl_end[i]) begin
            if (!(cfg_oneshot[a] && tbl_used[i])) begin
               act_pending[a] = 1'b1;
               act_value[a]   = tbl_param[i];
               tbl_used[i]    = 1'b1;
            end
         end else if (tbl_used[i] && pos >= tbl_end[i]) begin
            tbl_used[i]    = 1'b0;
            act_pending[a] = 1'b0;
         end
      end
   endfunction

   // Apply one request to the shadow state, return the response it gives
   function automatic rsp_payload_type cue_trigger_step(input cue_request_type r);
      rsp_payload_type res;
      logic [ACT_W-1:0] a;
      res = '0;
      a   = r.fields.action_id;
      case (r.opcode)
         OP_LOAD: begin
            tbl_start[r.fields.entry_index]  = r.fields.window_start;
            tbl_end[r.fields.entry_index]    = r.fields.window_end;
            tbl_action[r.fields.entry_index] = a;
            tbl_param[r.fields.entry_index]  = r.fields.action_param;
         end
         OP_TICK: walk_cues(r.fields.position);
         OP_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) tbl_used[i] = 1'b0;
            for (int k = 0; k < ACTIONS; k++) act_pending[k] = 1'b0;
         end
         OP_POLL: begin
            res.fired = act_pending[a];
            if (act_pending[a] && cfg_oneshot[a]) act_pending[a] = 1'b0;
            res.param_out = act_value[a];
         end
         OP_READ: res.param_out = act_value[a];
         default: ;
      endcase
      return res;
   endfunction

   // Request driver: takes beats from request_q, predicts on accept
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            cue_request_type acc;
            rsp_payload_type pred;
            acc.opcode = req_tuser;
            acc.fields = req_payload_type'(req_tdata);
            pred = cue_trigger_step(acc);
            predicted_q.insert(predicted_q.size(), pred);
            req_count++;
            if (acc.opcode == OP_TICK) tick_count++;
            if (pred.fired) poll_hits++;
         end
         if (!req_tvalid || req_tready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cue_request_type nxt;
               nxt = request_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.opcode;
               req_tdata  <= nxt.fields;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compares each beat with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_payload_type got, want;
            got = rsp_payload_type'(rsp_tdata);
            rsp_count++;
            if (predicted_q.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatch_count++;
            end else begin
               want = predicted_q.pop_front();
               if (got.fired !== want.fired) begin
                  $error("fired: expected %0d, got %0d", want.fired, got.fired);
                  mismatch_count++;
               end
               if (got.param_out !== want.param_out) begin
                  $error("param_out: expected %0d, got %0d", want.param_out, got.param_out);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Random values in every field; the opcode decides which ones matter
   function automatic cue_request_type noisy_request(input logic [OP_W-1:0] op);
      cue_request_type r;
      r.opcode                = op;
      r.fields                = '0;
      r.fields.entry_index    = IDX_W'($urandom);
      r.fields.window_start   = TIME_W'($urandom);
      r.fields.window_end     = TIME_W'($urandom);
      r.fields.action_id      = ACT_W'($urandom);
      r.fields.action_param   = PARAM_W'(int'($urandom_range(128)) - 1);
      r.fields.position       = TIME_W'($urandom);
      return r;
   endfunction

   function automatic cue_request_type load_req(input int idx, input logic [TIME_W-1:0] s,
                                                input logic [TIME_W-1:0] e, input int a,
                                                input int p);
      cue_request_type r;
      r = noisy_request(OP_LOAD);
      r.fields.entry_index  = IDX_W'(idx);
      r.fields.window_start = s;
      r.fields.window_end   = e;
      r.fields.action_id    = ACT_W'(a);
      r.fields.action_param = PARAM_W'(p);
      return r;
   endfunction

   function automatic cue_request_type tick_req(input logic [TIME_W-1:0] pos);
      cue_request_type r;
      r = noisy_request(OP_TICK);
      r.fields.position = pos;
      return r;
   endfunction

   function automatic cue_request_type action_req(input logic [OP_W-1:0] op, input int a);
      cue_request_type r;
      r = noisy_request(op);
      r.fields.action_id = ACT_W'(a);
      return r;
   endfunction

   // Favor a few actions so that entries override each other
   function automatic int pick_action();
      return $urandom_range(1) ? $urandom_range(3) : $urandom_range(ACTIONS - 1);
   endfunction

   function automatic logic [TIME_W-1:0] near_time(input int span);
      return ($urandom_range(15) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(span));
   endfunction

   // Random entry: mostly short windows on the timeline, some empty or inverted
   function automatic cue_request_type random_load(input int idx);
      logic [TIME_W-1:0] s, e;
      s = near_time(WIN_SPAN);
      case ($urandom_range(9))
         0:       e = s;
         1:       e = TIME_W'($urandom_range(s));
         default: e = s + TIME_W'($urandom_range(MAX_LEN, 1));
      endcase
      return load_req(idx, s, e, pick_action(), int'($urandom_range(128)) - 1);
   endfunction

   // Timeline playback with small steps, some rewinds and stray positions
   function automatic cue_request_type random_request();
      int r;
      r = $urandom_range(99);
      if (r < 18) return random_load($urandom_range(ENTRIES - 1));
      if (r < 58) begin
         r = $urandom_range(99);
         if (r < 5) return tick_req(TIME_W'($urandom));
         if (r < 10) tl_pos = $urandom_range(tl_pos);
         else tl_pos += $urandom_range(48);
         if (tl_pos > TL_SPAN) tl_pos = 0;
         return tick_req(TIME_W'(tl_pos));
      end
      if (r < 83) return action_req(OP_POLL, pick_action());
      if (r < 93) return action_req(OP_READ, pick_action());
      if (r < 97) return noisy_request(OP_CLEAR);
      return noisy_request(OP_W'($urandom_range((1 << OP_W) - 1, int'(OP_READ) + 1)));
   endfunction

   task automatic wait_for_quiet();
      do @(negedge clock);
      while (request_q.size() != 0 || req_tvalid || predicted_q.size() != 0);
   endtask

   // Both registers back to back, with the write enable held across them
   task automatic program_regs(input int active, input int mask);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= CSR_ACTIVE;
      csr_wdata <= CSR_DATA_W'(active);
      @(posedge clock);
      csr_addr  <= CSR_MASK;
      csr_wdata <= CSR_DATA_W'(mask);
      @(posedge clock);
      csr_wen   <= 1'b0;
      cfg_active  = ACTIVE_W'(active);
      cfg_oneshot = MASK_W'(mask);
      setting_count++;
   endtask

   // Run limit, far above the slowest legal run
   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int ph_active [PHASES] = '{4, 32, 63, 17, 0, 1, 33};
      int ph_mask   [PHASES] = '{16'hFFFF, 16'h0000, 16'h5A5A, 16'hA5A5, 16'hFFFF,
                                 16'h8001, 16'h0F0F};
      int ph_send   [PHASES] = '{0, 70, 0, 26, 70, 0, 26};
      int ph_stall  [PHASES] = '{0, 0, 70, 26, 0, 70, 26};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings: nothing walked yet
      add_request(action_req(OP_READ, 0));
      add_request(action_req(OP_POLL, ACTIONS - 1));
      for (int op = int'(OP_READ) + 1; op < (1 << OP_W); op++)
         add_request(noisy_request(OP_W'(op)));
      add_request(load_req(0, 24'h000100, 24'h000300, 0, 127));
      add_request(load_req(1, 24'h000200, 24'h000400, 0, -1));
      add_request(load_req(2, 24'h000500, 24'h000500, 1, 5));
      add_request(load_req(3, TIME_MAX, 24'h000000, ACTIONS - 1, 9));
      add_request(load_req(ENTRIES - 1, 24'h000000, TIME_MAX, ACTIONS - 1, 64));
      add_request(tick_req(24'h000250));
      add_request(action_req(OP_READ, 0));
      wait_for_quiet();
      program_regs(4, 16'hFFFF);

      // Directed: override, one-shot poll, no refire, expiry, clear
      add_request(tick_req(24'h000250));
      add_request(action_req(OP_READ, 0));
      add_request(action_req(OP_POLL, 0));
      add_request(action_req(OP_POLL, 0));
      add_request(tick_req(24'h000260));
      add_request(action_req(OP_POLL, 0));
      add_request(tick_req(24'h000500));
      add_request(tick_req(24'h000180));
      add_request(action_req(OP_READ, 0));
      add_request(noisy_request(OP_CLEAR));
      add_request(action_req(OP_POLL, 0));
      add_request(tick_req(24'h000000));
      add_request(tick_req(TIME_MAX));
      add_request(action_req(OP_POLL, 1));
      wait_for_quiet();

      // Random phases; the first one fills the whole table
      for (int ph = 0; ph < PHASES; ph++) begin
         program_regs(ph_active[ph], ph_mask[ph]);
         send_idle_pct  = ph_send[ph];
         recv_stall_pct = ph_stall[ph];
         if (ph == 0)
            for (int i = 0; i < ENTRIES; i++) add_request(random_load(i));
         for (int k = 0; k < PHASE_REQS; k++) add_request(random_request());
         wait_for_quiet();
      end

      repeat (ENTRIES + 8) @(posedge clock);
      $display("Checked %0d responses to %0d requests (%0d ticks) under %0d register settings,",
               rsp_count, req_count, tick_count, setting_count);
      $display("with %0d polls that found an action pending.", poll_hits);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
